// ===== hdl/ffr_pkg.sv =====
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared types and constants for the fixed frame receiver.
// ----------------------------------------------------------------------------
package ffr_pkg;

    // Number of data bytes carried by one frame (1 to 8).
    localparam int DATA_BYTES = 8;

    // Widths of the data byte index, the byte counter, the packed payload and the configuration index.
    localparam int IDX_W      = 3;
    localparam int CNT_W      = 4;
    localparam int PAYLOAD_W  = 64;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND_ALT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ID        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND       = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_HEADER_FIRST      = 8'd170;
    localparam logic [7:0] RST_HEADER_SECOND     = 8'd187;
    localparam logic [7:0] RST_HEADER_SECOND_ALT = 8'd187;
    localparam logic [7:0] RST_CHANNEL_ID        = 8'd10;
    localparam logic [7:0] RST_TAIL_FIRST        = 8'd238;
    localparam logic [7:0] RST_TAIL_SECOND       = 8'd255;

    // Parser phases, one-hot.
    typedef enum logic [9:0] {
        PH_H1   = 10'b00_0000_0001,
        PH_H2   = 10'b00_0000_0010,
        PH_CID  = 10'b00_0000_0100,
        PH_FC   = 10'b00_0000_1000,
        PH_SFC  = 10'b00_0001_0000,
        PH_DATA = 10'b00_0010_0000,
        PH_CSH  = 10'b00_0100_0000,
        PH_CSL  = 10'b00_1000_0000,
        PH_T1   = 10'b01_0000_0000,
        PH_T2   = 10'b10_0000_0000
    } t_phase;

endpackage

// ===== hdl/fixed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// fixed_frame_receiver
// Recognizes 17-byte serial frames and emits the codes and packed data.
// ----------------------------------------------------------------------------
// Usage:
// One received byte enters on i_rx_byte per input beat (i_in_valid high and
// o_in_stall low at a rising edge). The byte is registered, then the parser
// checks it against the header, channel ID, checksum and tail settings in the
// next cycle. A frame with a good checksum and good tail bytes produces one
// output beat on o_out_valid with the function code, subfunction code and the
// eight data bytes (first byte in bits 63 to 56).
// The second tail byte passes through the input register and the parser into
// the output register. Throughput: one byte per cycle while the output is free.
// When the output is stalled, the result is held in the output register; bytes
// that produce no result keep flowing, and only a byte that would complete a
// second frame waits. The configuration channel (i_cfg_valid, o_cfg_ready,
// i_cfg_index, i_cfg_data) writes one register per beat; indexes above five
// are ignored. Synchronous reset restores the register defaults and sends
// the parser back to waiting for the first header byte.
// ----------------------------------------------------------------------------
module fixed_frame_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Byte input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_rx_byte,
    // Frame output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_function_code,
    output logic [7:0]                     o_subfunction_code,
    output logic [ffr_pkg::PAYLOAD_W-1:0]  o_payload,
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import ffr_pkg::*;

    // Configuration registers
    logic [7:0] r_header_first;
    logic [7:0] r_header_second;
    logic [7:0] r_header_second_alt;
    logic [7:0] r_channel_id;
    logic [7:0] r_tail_first;
    logic [7:0] r_tail_second;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Parser state
    t_phase     r_phase, n_phase;
    logic [15:0] r_sum, n_sum;
    logic [7:0] r_sum_high;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0] r_func;
    logic [7:0] r_subfunc;
    logic [7:0] r_data [DATA_BYTES];

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_func;
    logic [7:0] r_out_subfunc;
    logic [PAYLOAD_W-1:0] r_out_payload;

    logic       emit;
    logic       adv;
    logic       out_free;
    logic [PAYLOAD_W-1:0] packed_data;

    // The configuration port is open whenever the block is out of reset.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first      <= RST_HEADER_FIRST;
            r_header_second     <= RST_HEADER_SECOND;
            r_header_second_alt <= RST_HEADER_SECOND_ALT;
            r_channel_id        <= RST_CHANNEL_ID;
            r_tail_first        <= RST_TAIL_FIRST;
            r_tail_second       <= RST_TAIL_SECOND;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEADER_FIRST:      r_header_first      <= i_cfg_data;
                CFG_HEADER_SECOND:     r_header_second     <= i_cfg_data;
                CFG_HEADER_SECOND_ALT: r_header_second_alt <= i_cfg_data;
                CFG_CHANNEL_ID:        r_channel_id        <= i_cfg_data;
                CFG_TAIL_FIRST:        r_tail_first        <= i_cfg_data;
                CFG_TAIL_SECOND:       r_tail_second       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A byte that completes a frame needs a free output register.
    assign emit     = (r_phase == PH_T2) && (r_in_byte == r_tail_second);
    assign out_free = !r_out_valid || !i_out_stall;
    assign adv      = r_in_valid && (out_free || !emit);
    assign o_in_stall = !i_rst_n || (r_in_valid && !adv);

    // Input register loads whenever the parser takes the held byte or it is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Next-state logic of the frame parser.
    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_count = r_count;
        case (r_phase)
            PH_H2: begin
                n_phase = (r_in_byte == r_header_second || r_in_byte == r_header_second_alt)
                          ? PH_CID : PH_H1;
            end
            PH_CID: begin
                if (r_in_byte == r_channel_id) begin
                    n_sum   = {8'd0, r_in_byte};
                    n_phase = PH_FC;
                end else begin
                    n_phase = PH_H1;
                end
            end
            PH_FC: begin
                n_sum   = r_sum + {8'd0, r_in_byte};
                n_phase = PH_SFC;
            end
            PH_SFC: begin
                n_sum   = r_sum + {8'd0, r_in_byte};
                n_count = '0;
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                n_sum   = r_sum + {8'd0, r_in_byte};
                n_count = r_count + CNT_W'(1);
                if (n_count >= CNT_W'(DATA_BYTES)) begin
                    n_phase = PH_CSH;
                end
            end
            PH_CSH: begin
                n_phase = PH_CSL;
            end
            PH_CSL: begin
                n_phase = ({r_sum_high, r_in_byte} == r_sum) ? PH_T1 : PH_H1;
            end
            PH_T1: begin
                n_phase = (r_in_byte == r_tail_first) ? PH_T2 : PH_H1;
            end
            PH_T2: begin
                n_phase = PH_H1;
            end
            default: begin
                n_phase = (r_in_byte == r_header_first) ? PH_H2 : PH_H1;
            end
        endcase
    end

    // Parser control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_H1;
            r_sum   <= '0;
            r_count <= '0;
            r_sum_high <= '0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_count <= n_count;
            if (r_phase == PH_CSH) begin
                r_sum_high <= r_in_byte;
            end
        end
    end

    // Held frame fields.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_phase == PH_FC) begin
                r_func <= r_in_byte;
            end
            if (r_phase == PH_SFC) begin
                r_subfunc <= r_in_byte;
            end
            if (r_phase == PH_DATA) begin
                r_data[r_count[IDX_W-1:0]] <= r_in_byte;
            end
        end
    end

    // Pack the data bytes, first byte at the top; unused lanes are zero.
    always_comb begin
        packed_data = '0;
        for (int i = 0; i < DATA_BYTES; i++) begin
            packed_data[PAYLOAD_W-1-8*i -: 8] = r_data[i];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out_func    <= r_func;
            r_out_subfunc <= r_subfunc;
            r_out_payload <= packed_data;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_function_code    = r_out_func;
    assign o_subfunction_code = r_out_subfunc;
    assign o_payload          = r_out_payload;

endmodule

// ===== hdl/ffr_checker.sv =====
// ----------------------------------------------------------------------------
// ffr_checker
// Port-level checks of the fixed frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ffr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [7:0]                     o_function_code,
    input  logic [7:0]                     o_subfunction_code,
    input  logic [ffr_pkg::PAYLOAD_W-1:0]  o_payload
);
    import ffr_pkg::*;

    logic in_beat;
    assign in_beat = i_in_valid && !o_in_stall;

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A new result only follows an input beat carried through the input register into the output register.
    a_result_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_beat, 2))
        else $error("result without a recent input beat");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    // A stalled result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_payload) && $stable(o_function_code)
            && $stable(o_subfunction_code))
        else $error("stalled result changed");

endmodule

bind fixed_frame_receiver ffr_checker u_ffr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_function_code    (o_function_code),
    .o_subfunction_code (o_subfunction_code),
    .o_payload          (o_payload)
);
